// ===== design/assert_macros.svh =====
// Assertion helpers shared by the modules that check themselves.
// Each one expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never be true on a clock edge out of reset
`define VSH_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

// when ante holds, cons must hold on the same edge
`define VSH_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/vsh_pkg.sv =====
package vsh_pkg;

	// opcodes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// store selects for a read
	localparam logic [2:0] SEL_RED   = 3'd0;
	localparam logic [2:0] SEL_GREEN = 3'd1;
	localparam logic [2:0] SEL_BLUE  = 3'd2;
	localparam logic [2:0] SEL_LUMA  = 3'd3;
	localparam logic [2:0] SEL_WAVE  = 3'd4;
	localparam logic [2:0] SEL_VEC   = 3'd5;

	// Q0.16 luma and chroma coefficients
	localparam int COEF_R = 13933;
	localparam int COEF_G = 46871;
	localparam int COEF_B = 4732;
	localparam int COEF_U = 41615;
	localparam int COEF_V = 35324;

	// widest waveform column the item format carries
	localparam int PCOL_BITS = 12;

	typedef enum logic [1:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_EXEC
	} back_state_t;

	// fields that ride along the front pipeline unchanged
	typedef struct packed {
		logic [1:0]           op;
		logic [PCOL_BITS-1:0] pcol;
		logic [2:0]           read_store;
		logic [7:0]           read_row;
		logic [9:0]           read_col;
		logic                 bad;
	} pass_t;

	// classified item handed from front to back
	typedef struct packed {
		pass_t      p;
		logic [7:0] rbin;
		logic [7:0] gbin;
		logic [7:0] bbin;
		logic [7:0] ybin;
		logic [7:0] ubin;
		logic [7:0] vbin;
	} item_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef struct packed {
		logic ready;
		logic empty;
	} fifo_stat_t;

	// clamp(v,0,1)*255 truncated, v in Q.12
	function automatic logic [7:0] bin_q12(input logic signed [15:0] v);
		logic [24:0] m;
		m = (25'(v) << 8) - 25'(v);
		if (v <= 16'sd0)
			return 8'd0;
		if (v >= 16'sd4096)
			return 8'd255;
		return m[19:12];
	endfunction

	// same for Q.28
	function automatic logic [7:0] bin_q28(input logic signed [32:0] v);
		logic [36:0] m;
		m = (37'(v) << 8) - 37'(v);
		if (v <= 33'sd0)
			return 8'd0;
		if (v >= (33'sd1 <<< 28))
			return 8'd255;
		return m[35:28];
	endfunction

	// same for Q.44
	function automatic logic [7:0] bin_q44(input logic signed [51:0] v);
		logic [52:0] m;
		m = (53'(v) << 8) - 53'(v);
		if (v <= 52'sd0)
			return 8'd0;
		if (v >= (52'sd1 <<< 44))
			return 8'd255;
		return m[51:44];
	endfunction

endpackage

// ===== design/vsh_fifo.sv =====
module vsh_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vsh_pkg::item_t din,
	input  logic           pop,
	output vsh_pkg::item_t dout,
	output vsh_pkg::fifo_stat_t stat
);
	import vsh_pkg::*;

	item_t      mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	assign dout       = mem_q[rd_q];
	assign stat.ready = (cnt_q != 3'd4);
	assign stat.empty = (cnt_q == 3'd0);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 2'd1;
			if (pop)
				rd_q <= rd_q + 2'd1;
			if (push && !pop)
				cnt_q <= cnt_q + 3'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 3'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

endmodule

// ===== design/vsh_front.sv =====
module vsh_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [10:0]         frame_width,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          opcode,
	input  logic signed [15:0]  red_in,
	input  logic signed [15:0]  green_in,
	input  logic signed [15:0]  blue_in,
	input  logic [2:0]          read_store,
	input  logic [7:0]          read_row,
	input  logic [9:0]          read_col,
	input  vsh_pkg::back_stat_t bstat,
	input  vsh_pkg::fifo_stat_t fstat,
	output logic                push,
	output vsh_pkg::item_t      item
);
	import vsh_pkg::*;

	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int WX = (WB > 11) ? WB : 11;
	localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic          adv;
	logic          take;
	logic [WX-1:0] fw_x;
	logic [WX-1:0] eff_w;
	logic [WX-1:0] col_x;
	logic [WX-1:0] col_nx;
	logic [CB-1:0] col_q;
	logic          bad_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	pass_t p_s1, p_s2, p_s3, p_s4, p_s5;
	logic signed [32:0] pr_s1, pg_s1, pb_s1;
	logic signed [15:0] r_s1, g_s1, b_s1;
	logic signed [32:0] y_s2;
	logic signed [15:0] r_s2, b_s2;
	logic [7:0] rb_s2, gb_s2, bb_s2, rb_s3, gb_s3, bb_s3, rb_s4, gb_s4, bb_s4;
	logic [7:0] rb_s5, gb_s5, bb_s5;
	logic [7:0] yb_s3, yb_s4, yb_s5, ub_s5, vb_s5;
	logic signed [33:0] du_s3, dv_s3;
	logic signed [51:0] mu_s4, mv_s4;

	// whole pipeline moves together unless the last stage is stuck
	assign adv      = !v_s5 || fstat.ready;
	assign in_ready = adv && !bstat.clearing;
	assign take     = in_valid && in_ready;
	assign push     = v_s5 && fstat.ready;

	// effective width and the column this pixel lands in
	always_comb begin
		fw_x   = WX'(frame_width);
		eff_w  = (fw_x == '0) ? WX'(1) : ((fw_x > WX'(MAX_WIDTH)) ? WX'(MAX_WIDTH) : fw_x);
		col_x  = (WX'(col_q) < eff_w) ? WX'(col_q) : '0;
		col_nx = col_x + WX'(1);
	end

	// read address check
	always_comb begin
		case (read_store)
			SEL_RED, SEL_GREEN, SEL_BLUE, SEL_LUMA: bad_c = 1'b0;
			SEL_WAVE: bad_c = !(WX'(read_col) < eff_w);
			SEL_VEC:  bad_c = (read_col > 10'd255);
			default:  bad_c = 1'b1;
		endcase
	end

	// valids and column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			col_q <= '0;
		end else begin
			if (adv) begin
				v_s1 <= take && (opcode != OP_NOP);
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
			end
			if (take && opcode == OP_CLEAR)
				col_q <= '0;
			else if (take && opcode == OP_PIXEL)
				col_q <= (col_nx >= eff_w) ? '0 : CB'(col_nx);
		end
	end

	// datapath stages: products, luma, chroma differences, scaling, bins
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1.op         <= opcode;
			p_s1.pcol       <= PCOL_BITS'(col_x);
			p_s1.read_store <= read_store;
			p_s1.read_row   <= read_row;
			p_s1.read_col   <= read_col;
			p_s1.bad        <= bad_c;
			pr_s1 <= 33'(red_in) * 33'sd13933;
			pg_s1 <= 33'(green_in) * 33'sd46871;
			pb_s1 <= 33'(blue_in) * 33'sd4732;
			r_s1  <= red_in;
			g_s1  <= green_in;
			b_s1  <= blue_in;

			p_s2  <= p_s1;
			y_s2  <= pr_s1 + pg_s1 + pb_s1;
			r_s2  <= r_s1;
			b_s2  <= b_s1;
			rb_s2 <= bin_q12(r_s1);
			gb_s2 <= bin_q12(g_s1);
			bb_s2 <= bin_q12(b_s1);

			p_s3  <= p_s2;
			rb_s3 <= rb_s2;
			gb_s3 <= gb_s2;
			bb_s3 <= bb_s2;
			yb_s3 <= bin_q28(y_s2);
			du_s3 <= (34'(r_s2) <<< 16) - 34'(y_s2);
			dv_s3 <= (34'(b_s2) <<< 16) - 34'(y_s2);

			p_s4  <= p_s3;
			rb_s4 <= rb_s3;
			gb_s4 <= gb_s3;
			bb_s4 <= bb_s3;
			yb_s4 <= yb_s3;
			mu_s4 <= 52'(du_s3) * 52'sd41615;
			mv_s4 <= 52'(dv_s3) * 52'sd35324;

			p_s5  <= p_s4;
			rb_s5 <= rb_s4;
			gb_s5 <= gb_s4;
			bb_s5 <= bb_s4;
			yb_s5 <= yb_s4;
			ub_s5 <= bin_q44(mu_s4 + (52'sd1 <<< 43));
			vb_s5 <= bin_q44(mv_s4 + (52'sd1 <<< 43));
		end
	end

	always_comb begin
		item.p    = p_s5;
		item.rbin = rb_s5;
		item.gbin = gb_s5;
		item.bbin = bb_s5;
		item.ybin = yb_s5;
		item.ubin = ub_s5;
		item.vbin = vb_s5;
	end

endmodule

// ===== design/vsh_back.sv =====
module vsh_back #(
	parameter int MAX_WIDTH  = 1024,
	parameter int COUNT_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vsh_pkg::item_t       head,
	input  vsh_pkg::fifo_stat_t  fstat,
	output logic                 pop,
	output vsh_pkg::back_stat_t  stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [23:0]          read_count,
	output logic                 bad_index
);
	import vsh_pkg::*;

	localparam int WF_DEPTH = 256 * MAX_WIDTH;
	localparam int WA       = $clog2(WF_DEPTH);
	localparam int SWEEP    = (WF_DEPTH > 65536) ? WF_DEPTH : 65536;
	localparam int SWB      = $clog2(SWEEP);
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] r_mem [256];
	logic [COUNT_BITS-1:0] g_mem [256];
	logic [COUNT_BITS-1:0] b_mem [256];
	logic [COUNT_BITS-1:0] y_mem [256];
	logic [COUNT_BITS-1:0] wf_mem [WF_DEPTH];
	logic [COUNT_BITS-1:0] vs_mem [65536];

	back_state_t state_q, state_d;
	logic [SWB-1:0] clr_q;
	item_t cur_q;
	logic out_valid_q;
	logic [23:0] count_q;
	logic bad_q;

	logic [7:0]  ra_r, ra_g, ra_b, ra_y;
	logic [WA-1:0] ra_w;
	logic [15:0] ra_v;
	logic [7:0]  wa_r_q, wa_g_q, wa_b_q, wa_y_q;
	logic [WA-1:0] wa_w_q;
	logic [15:0] wa_v_q;
	logic [COUNT_BITS-1:0] rd_r, rd_g, rd_b, rd_y, rd_w, rd_v;
	logic clearing, upd, wf_clr_ok;
	logic [COUNT_BITS-1:0] sel;

	assign clearing   = (state_q == BS_CLEAR);
	assign upd        = (state_q == BS_EXEC) && (cur_q.p.op == OP_PIXEL);
	assign wf_clr_ok  = (32'(clr_q) < WF_DEPTH);
	assign stat.clearing = clearing;
	assign out_valid  = out_valid_q;
	assign read_count = count_q;
	assign bad_index  = bad_q;

	// read addresses come straight from the queue head
	always_comb begin
		if (head.p.op == OP_PIXEL) begin
			ra_r = head.rbin;
			ra_g = head.gbin;
			ra_b = head.bbin;
			ra_y = head.ybin;
			ra_w = WA'(head.ybin) * WA'(MAX_WIDTH) + WA'(head.p.pcol);
			ra_v = {head.ubin, head.vbin};
		end else begin
			ra_r = head.p.read_row;
			ra_g = head.p.read_row;
			ra_b = head.p.read_row;
			ra_y = head.p.read_row;
			ra_w = WA'(head.p.read_row) * WA'(MAX_WIDTH) + WA'(head.p.read_col);
			ra_v = {head.p.read_row, head.p.read_col[7:0]};
		end
	end

	// sequencer: pop, then update, answer or start a clear sweep
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			BS_CLEAR: begin
				if (clr_q == SWB'(SWEEP - 1))
					state_d = BS_IDLE;
			end
			BS_IDLE: begin
				if (!fstat.empty && (head.p.op != OP_READ || !out_valid_q)) begin
					pop     = 1'b1;
					state_d = (head.p.op == OP_CLEAR) ? BS_CLEAR : BS_EXEC;
				end
			end
			BS_EXEC: state_d = BS_IDLE;
			default: state_d = BS_IDLE;
		endcase
	end

	// count selected by a read
	always_comb begin
		case (cur_q.p.read_store)
			SEL_RED:   sel = rd_r;
			SEL_GREEN: sel = rd_g;
			SEL_BLUE:  sel = rd_b;
			SEL_LUMA:  sel = rd_y;
			SEL_WAVE:  sel = rd_w;
			SEL_VEC:   sel = rd_v;
			default:   sel = '0;
		endcase
		if (cur_q.p.bad)
			sel = '0;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop)
				clr_q <= '0;
			else if (clearing)
				clr_q <= clr_q + SWB'(1);
			if (state_q == BS_EXEC && cur_q.p.op == OP_READ)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= head;
			wa_r_q <= ra_r;
			wa_g_q <= ra_g;
			wa_b_q <= ra_b;
			wa_y_q <= ra_y;
			wa_w_q <= ra_w;
			wa_v_q <= ra_v;
		end
		if (state_q == BS_EXEC && cur_q.p.op == OP_READ) begin
			count_q <= 24'(sel);
			bad_q   <= cur_q.p.bad;
		end
	end

	// histograms: clear sweep or saturating increment
	always_ff @(posedge clk) begin
		if (clearing) begin
			r_mem[clr_q[7:0]] <= '0;
			g_mem[clr_q[7:0]] <= '0;
			b_mem[clr_q[7:0]] <= '0;
			y_mem[clr_q[7:0]] <= '0;
		end else if (upd) begin
			r_mem[wa_r_q] <= (rd_r == CMAX) ? rd_r : rd_r + 1'b1;
			g_mem[wa_g_q] <= (rd_g == CMAX) ? rd_g : rd_g + 1'b1;
			b_mem[wa_b_q] <= (rd_b == CMAX) ? rd_b : rd_b + 1'b1;
			y_mem[wa_y_q] <= (rd_y == CMAX) ? rd_y : rd_y + 1'b1;
		end
		rd_r <= r_mem[ra_r];
		rd_g <= g_mem[ra_g];
		rd_b <= b_mem[ra_b];
		rd_y <= y_mem[ra_y];
	end

	// waveform store
	always_ff @(posedge clk) begin
		if (clearing && wf_clr_ok)
			wf_mem[clr_q[WA-1:0]] <= '0;
		else if (upd)
			wf_mem[wa_w_q] <= (rd_w == CMAX) ? rd_w : rd_w + 1'b1;
		rd_w <= wf_mem[ra_w];
	end

	// vectorscope store
	always_ff @(posedge clk) begin
		if (clearing)
			vs_mem[clr_q[15:0]] <= '0;
		else if (upd)
			vs_mem[wa_v_q] <= (rd_v == CMAX) ? rd_v : rd_v + 1'b1;
		rd_v <= vs_mem[ra_v];
	end

endmodule

// ===== design/video_scope_histograms.sv =====
// Video scope engine: red, green, blue and luma histograms, a luma waveform
// and a vectorscope, built from signed Q3.12 RGB pixels. The front end takes
// one beat per clock, unless a full queue or a sweep holds it, into a
// five-stage classification pipeline and a four-entry queue; the back end
// takes one pixel or read at a time (registered read of every store, then
// the saturating write or the answer). A clear, and reset itself, starts a
// sweep that zeroes the stores one address per cycle across the larger of
// the waveform and vectorscope depths, max(256*MAX_WIDTH, 65536); no beat
// is accepted during the sweep. frame_width may be written any time the
// engine is idle and is clamped to 1..MAX_WIDTH.
`include "assert_macros.svh"

module video_scope_histograms #(
	parameter int MAX_WIDTH  = 1024,
	parameter int COUNT_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [10:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] red_in,
	input  logic signed [15:0] green_in,
	input  logic signed [15:0] blue_in,
	input  logic [2:0]         read_store,
	input  logic [7:0]         read_row,
	input  logic [9:0]         read_col,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [23:0]        read_count,
	output logic               bad_index
);
	import vsh_pkg::*;

	logic [10:0] frame_width_q;
	back_stat_t  bstat;
	fifo_stat_t  fstat;
	logic        fifo_push;
	logic        fifo_pop;
	item_t       front_item;
	item_t       head_item;

	assign cfg_ready = 1'b1;

	// frame width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frame_width_q <= 11'd1024;
		else if (cfg_valid && cfg_ready)
			frame_width_q <= cfg_data;
	end

	vsh_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_width (frame_width_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.read_store  (read_store),
		.read_row    (read_row),
		.read_col    (read_col),
		.bstat       (bstat),
		.fstat       (fstat),
		.push        (fifo_push),
		.item        (front_item)
	);

	vsh_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.din    (front_item),
		.pop    (fifo_pop),
		.dout   (head_item),
		.stat   (fstat)
	);

	vsh_back #(.MAX_WIDTH(MAX_WIDTH), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_item),
		.fstat      (fstat),
		.pop        (fifo_pop),
		.stat       (bstat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_count (read_count),
		.bad_index  (bad_index)
	);

	`VSH_ASSERT_NEVER(a_no_take_in_sweep, bstat.clearing && in_ready, "beat taken during clear sweep")
	`VSH_ASSERT_NEVER(a_no_pop_in_sweep, bstat.clearing && fifo_pop, "queue popped during clear sweep")
	`VSH_ASSERT_IMPLY(a_bad_reads_zero, out_valid && bad_index, read_count == 24'd0, "bad read nonzero")

endmodule

// ===== sim/video_scope_histograms_tb.sv =====
module video_scope_histograms_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vsh_pkg::*;

	localparam int          WAVE_COLS  = 1024;
	localparam int unsigned COUNT_TOP  = 24'hFFFFFF;
	localparam int          SETTLE_CYC = 60;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [10:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         opcode;
	logic signed [15:0] red_in;
	logic signed [15:0] green_in;
	logic signed [15:0] blue_in;
	logic [2:0]         read_store;
	logic [7:0]         read_row;
	logic [9:0]         read_col;
	logic               out_valid;
	logic               out_ready;
	logic [23:0]        read_count;
	logic               bad_index;

	video_scope_histograms dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.read_store(read_store),
		.read_row(read_row),
		.read_col(read_col),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_count(read_count),
		.bad_index(bad_index)
	);

	typedef struct {
		logic [23:0] count;
		logic        bad;
	} answer_t;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] r;
		logic signed [15:0] g;
		logic signed [15:0] b;
		logic [2:0]         sel;
		logic [7:0]         row;
		logic [9:0]         col;
		bit                 typed;
		logic [23:0]        count;
		logic               bad;
	} stim_row_t;

	typedef struct {
		logic [2:0] sel;
		logic [7:0] row;
		logic [9:0] col;
	} cell_t;

	// scope model state
	int unsigned red_h[int];
	int unsigned green_h[int];
	int unsigned blue_h[int];
	int unsigned luma_h[int];
	int unsigned wave_h[int];
	int unsigned vec_h[int];
	int unsigned column_pos;
	int unsigned frame_w;

	answer_t   pending_answers[$];
	cell_t     hot_cells[$];
	stim_row_t plan[$];
	int        mismatches;
	bit        burst;
	bit        hold_req;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int unsigned bin_at(longint v, int frac);
		if (v <= 0)
			return 0;
		if (v >= (longint'(1) <<< frac))
			return 255;
		return int'((v * 255) >>> frac);
	endfunction

	function automatic int unsigned width_eff();
		if (frame_w < 1)
			return 1;
		if (frame_w > WAVE_COLS)
			return WAVE_COLS;
		return frame_w;
	endfunction

	function automatic int unsigned peek(ref int unsigned store[int], input int idx);
		return store.exists(idx) ? store[idx] : 0;
	endfunction

	function automatic void bump(ref int unsigned store[int], input int idx);
		int unsigned c;
		c = peek(store, idx);
		if (c < COUNT_TOP)
			store[idx] = c + 1;
	endfunction

	function automatic void remember(logic [2:0] sel, int row, int col);
		cell_t c;
		c.sel = sel;
		c.row = row[7:0];
		c.col = col[9:0];
		hot_cells.push_back(c);
		if (hot_cells.size() > 48)
			void'(hot_cells.pop_front());
	endfunction

	// accumulate one pixel into every store
	function automatic void scope_pixel(logic signed [15:0] r16, logic signed [15:0] g16,
			logic signed [15:0] b16);
		longint r, g, b, y, u, v;
		int unsigned ybin, ubin, vbin, w, col;
		r = r16;
		g = g16;
		b = b16;
		y = longint'(COEF_R) * r + longint'(COEF_G) * g + longint'(COEF_B) * b;
		u = (r * 65536 - y) * longint'(COEF_U) + (longint'(1) <<< 43);
		v = (b * 65536 - y) * longint'(COEF_V) + (longint'(1) <<< 43);
		ybin = bin_at(y, 28);
		ubin = bin_at(u, 44);
		vbin = bin_at(v, 44);
		w = width_eff();
		col = (column_pos < w) ? column_pos : 0;
		bump(red_h, bin_at(r, 12));
		bump(green_h, bin_at(g, 12));
		bump(blue_h, bin_at(b, 12));
		bump(luma_h, ybin);
		bump(wave_h, ybin * WAVE_COLS + col);
		bump(vec_h, ubin * 256 + vbin);
		remember(SEL_RED, bin_at(r, 12), 0);
		remember(SEL_GREEN, bin_at(g, 12), 0);
		remember(SEL_BLUE, bin_at(b, 12), 0);
		remember(SEL_LUMA, ybin, 0);
		remember(SEL_WAVE, ybin, col);
		remember(SEL_VEC, ubin, vbin);
		col = col + 1;
		column_pos = (col >= w) ? 0 : col;
	endfunction

	function automatic void scope_clear();
		red_h.delete();
		green_h.delete();
		blue_h.delete();
		luma_h.delete();
		wave_h.delete();
		vec_h.delete();
		hot_cells.delete();
		column_pos = 0;
	endfunction

	function automatic answer_t scope_read(logic [2:0] sel, logic [7:0] row, logic [9:0] col);
		answer_t a;
		int unsigned c;
		c = 0;
		a.bad = 1'b0;
		case (sel)
			SEL_RED:   c = peek(red_h, row);
			SEL_GREEN: c = peek(green_h, row);
			SEL_BLUE:  c = peek(blue_h, row);
			SEL_LUMA:  c = peek(luma_h, row);
			SEL_WAVE: begin
				if (col < width_eff())
					c = peek(wave_h, row * WAVE_COLS + col);
				else
					a.bad = 1'b1;
			end
			SEL_VEC: begin
				if (col <= 255)
					c = peek(vec_h, row * 256 + col);
				else
					a.bad = 1'b1;
			end
			default: a.bad = 1'b1;
		endcase
		a.count = c[23:0];
		return a;
	endfunction

	// model update for one accepted beat
	function automatic void scope_step(stim_row_t s);
		answer_t a;
		case (s.op)
			OP_CLEAR: scope_clear();
			OP_PIXEL: scope_pixel(s.r, s.g, s.b);
			OP_READ: begin
				if (s.typed) begin
					a.count = s.count;
					a.bad = s.bad;
				end else begin
					a = scope_read(s.sel, s.row, s.col);
				end
				pending_answers.push_back(a);
			end
			default: ;
		endcase
	endfunction

	function automatic void add_row(logic [1:0] op, int r, int g, int b, logic [2:0] sel,
			int row, int col, bit typed = 0, int count = 0, bit bad = 0);
		stim_row_t s;
		s.op = op;
		s.r = r[15:0];
		s.g = g[15:0];
		s.b = b[15:0];
		s.sel = sel;
		s.row = row[7:0];
		s.col = col[9:0];
		s.typed = typed;
		s.count = count[23:0];
		s.bad = bad;
		plan.push_back(s);
	endfunction

	function automatic logic [15:0] pick_component();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 4096));
			1: return 16'($urandom);
			2: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'd0;
					3: return 16'd4096;
					default: return 16'd4095;
				endcase
			end
			default: return 16'($urandom_range(0, 700)) - 16'd100;
		endcase
	endfunction

	function automatic stim_row_t random_beat();
		stim_row_t s;
		cell_t c;
		int k;
		s.typed = 0;
		s.count = '0;
		s.bad = 1'b0;
		s.r = pick_component();
		s.g = pick_component();
		s.b = pick_component();
		s.sel = 3'($urandom);
		s.row = 8'($urandom);
		s.col = 10'($urandom);
		k = $urandom_range(0, 99);
		if (k < 55) begin
			s.op = OP_PIXEL;
		end else if (k < 97) begin
			s.op = OP_READ;
			// most reads land on a cell a recent pixel touched
			if (hot_cells.size() > 0 && $urandom_range(0, 2) != 0) begin
				c = hot_cells[$urandom_range(0, hot_cells.size() - 1)];
				s.sel = c.sel;
				s.row = c.row;
				if (c.sel == SEL_WAVE || c.sel == SEL_VEC)
					s.col = c.col;
			end else if (s.sel == SEL_WAVE && $urandom_range(0, 1) == 0) begin
				s.col = 10'($urandom_range(0, width_eff() - 1));
			end else if (s.sel == SEL_VEC && $urandom_range(0, 1) == 0) begin
				s.col = 10'($urandom_range(0, 255));
			end
		end else begin
			s.op = OP_NOP;
		end
		return s;
	endfunction

	// offer one beat on the input channel
	task automatic send_beat(stim_row_t s);
		int gap;
		bit ok;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= s.op;
		red_in     <= s.r;
		green_in   <= s.g;
		blue_in    <= s.b;
		read_store <= s.sel;
		read_row   <= s.row;
		read_col   <= s.col;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		scope_step(s);
	endtask

	task automatic drain_answers();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_width(logic [10:0] w);
		bit ok;
		drain_answers();
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		frame_w = w;
	endtask

	// result side: random stalls, one long hold on request
	initial begin
		int n;
		bit ok;
		answer_t a, e;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				n = 400;
				hold_req = 1'b0;
			end else begin
				n = burst ? 0 : $urandom_range(0, 11);
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				ok = out_valid;
				a.count = read_count;
				a.bad = bad_index;
				@(posedge clk);
			end while (!ok);
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected read beat count=%0d bad=%0b",
					$time, a.count, a.bad);
				mismatches++;
			end else begin
				e = pending_answers.pop_front();
				if (a.count !== e.count) begin
					$display("%0t: read_count expected %0d actual %0d",
						$time, e.count, a.count);
					mismatches++;
				end
				if (a.bad !== e.bad) begin
					$display("%0t: bad_index expected %0b actual %0b",
						$time, e.bad, a.bad);
					mismatches++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int widths[7] = '{640, 7, 1, 0, 2047, 1024, 3};
		stim_row_t s;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		opcode     = OP_NOP;
		red_in     = '0;
		green_in   = '0;
		blue_in    = '0;
		read_store = SEL_RED;
		read_row   = '0;
		read_col   = '0;
		mismatches = 0;
		burst      = 1'b0;
		hold_req   = 1'b0;
		frame_w    = 1024;
		scope_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty stores, bad indexes, extreme pixels, clear
		add_row(OP_READ, 0, 0, 0, SEL_RED, 0, 0, 1, 0, 0);
		add_row(OP_READ, 0, 0, 0, SEL_WAVE, 0, 1023, 1, 0, 0);
		add_row(OP_READ, 0, 0, 0, SEL_VEC, 0, 300, 1, 0, 1);
		add_row(OP_READ, 0, 0, 0, 3'd6, 5, 5, 1, 0, 1);
		add_row(OP_READ, 0, 0, 0, 3'd7, 255, 1023, 1, 0, 1);
		add_row(OP_NOP, 4096, 4096, 4096, SEL_RED, 0, 0);
		add_row(OP_PIXEL, 32767, 32767, 32767, SEL_RED, 0, 0);
		add_row(OP_PIXEL, -32768, -32768, -32768, SEL_RED, 0, 0);
		add_row(OP_PIXEL, 4096, 4096, 4096, SEL_RED, 0, 0);
		add_row(OP_PIXEL, 0, 0, 0, SEL_RED, 0, 0);
		add_row(OP_PIXEL, 4095, 0, -1, SEL_RED, 0, 0);
		add_row(OP_PIXEL, 4096, 0, 0, SEL_RED, 0, 0);
		add_row(OP_PIXEL, 0, 0, 4096, SEL_RED, 0, 0);
		add_row(OP_READ, 0, 0, 0, SEL_RED, 255, 0);
		add_row(OP_READ, 0, 0, 0, SEL_GREEN, 0, 0);
		add_row(OP_READ, 0, 0, 0, SEL_BLUE, 255, 0);
		add_row(OP_READ, 0, 0, 0, SEL_LUMA, 255, 0);
		add_row(OP_READ, 0, 0, 0, SEL_WAVE, 255, 2);
		add_row(OP_READ, 0, 0, 0, SEL_WAVE, 0, 1);
		add_row(OP_READ, 0, 0, 0, SEL_VEC, 128, 128);
		add_row(OP_READ, 0, 0, 0, SEL_VEC, 255, 0);
		add_row(OP_CLEAR, 0, 0, 0, SEL_RED, 0, 0);
		add_row(OP_READ, 0, 0, 0, SEL_RED, 255, 0, 1, 0, 0);
		add_row(OP_READ, 0, 0, 0, SEL_LUMA, 0, 0, 1, 0, 0);
		foreach (plan[i])
			send_beat(plan[i]);

		// random phases, one per frame width
		foreach (widths[p]) begin
			write_width(11'(widths[p]));
			for (int i = 0; i < 235; i++) begin
				if (i % 40 == 0)
					burst = ($urandom_range(0, 3) == 0);
				if (p == 2 && i == 100)
					hold_req = 1'b1;
				if (p == 3 && i == 120)
					drain_answers();
				s = random_beat();
				if (p == 4 && i == 117)
					s.op = OP_CLEAR;
				send_beat(s);
			end
		end

		burst = 1'b0;
		drain_answers();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
